/* rtl/rtcm3_pkg.sv */
// ----------------------------------------------------------------------------
// RTCM3 deframer package
// Result type, queue status type, frame constants and the CRC-24Q byte update.
// ----------------------------------------------------------------------------
package rtcm3_pkg;

    localparam logic [7:0]  PreambleReset = 8'hD3;
    // CRC-24Q polynomial 0x1864CFB, x^24 term implicit
    localparam logic [23:0] CrcPoly       = 24'h864CFB;
    localparam logic [1:0]  LenHiMask     = 2'h3;
    localparam int unsigned TrailerBytes  = 3;
    localparam int unsigned LenW          = 10;
    localparam int unsigned LeftW         = 11;
    localparam int unsigned CrcW          = 24;
    localparam int unsigned ResQDepth     = 3;
    localparam int unsigned ResQLevelW    = $clog2(ResQDepth + 1);

    typedef struct packed {
        logic            crc_ok;
        logic [LenW-1:0] payload_length;
        logic [CrcW-1:0] received_crc;
    } t_result;

    typedef struct packed {
        logic [ResQLevelW-1:0] level;
    } t_q_stat;

    // One byte of CRC-24Q, MSB first
    function automatic logic [CrcW-1:0] crc24q_byte(input logic [CrcW-1:0] crc,
                                                   input logic [7:0]      b);
        logic [CrcW-1:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (c[CrcW-1]) begin
                c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[CrcW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/rtcm3_in_if.sv */
// ----------------------------------------------------------------------------
// RTCM3 byte channel
// Valid/ready channel carrying one received byte and the slot-free flag.
// ----------------------------------------------------------------------------
interface rtcm3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       slot_free;

    modport source(output valid, output data_byte, output slot_free, input ready);
    modport sink(input valid, input data_byte, input slot_free, output ready);
endinterface

/* rtl/rtcm3_out_if.sv */
// ----------------------------------------------------------------------------
// RTCM3 frame result channel
// Valid/ready channel carrying one frame result per item.
// ----------------------------------------------------------------------------
interface rtcm3_out_if;
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic [9:0]  payload_length;
    logic [23:0] received_crc;

    modport source(output valid, output crc_ok, output payload_length,
                   output received_crc, input ready);
    modport sink(input valid, input crc_ok, input payload_length,
                 input received_crc, output ready);
endinterface

/* rtl/rtcm3_parser.sv */
// ----------------------------------------------------------------------------
// RTCM3 frame parser
// Input register, frame state machine and running CRC-24Q; pushes one
// result into the result queue on the last trailer byte of a frame.
// ----------------------------------------------------------------------------
module rtcm3_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_slot_free,
    output logic              o_in_ready,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  rtcm3_pkg::t_q_stat i_q_stat,
    output logic              o_res_push,
    output rtcm3_pkg::t_result o_res
);
    import rtcm3_pkg::*;

    typedef enum logic [1:0] {
        PhSearch,
        PhLen1,
        PhLen2,
        PhBody
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [LeftW-1:0] r_left, n_left;
    logic [LenW-1:0]  r_len, n_len;
    logic [CrcW-1:0]  r_crc, n_crc;
    logic [CrcW-1:0]  r_trailer, n_trailer;
    logic [7:0]       r_preamble;
    logic             r_in_vld;
    logic [7:0]       r_byte;
    logic             r_slot;
    logic [CrcW-1:0]  crc_upd;
    logic [LenW-1:0]  len_full;
    logic             in_acc;

    // room for the held item plus the new one must exist in the queue
    assign o_in_ready = ({1'b0, i_q_stat.level} + {{ResQLevelW{1'b0}}, r_in_vld})
                        < (ResQLevelW+1)'(ResQDepth);
    assign in_acc     = i_in_valid && o_in_ready;

    assign crc_upd  = crc24q_byte(r_crc, r_byte);
    assign len_full = {r_len[LenW-1:8], r_byte};

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_len      = r_len;
        n_crc      = r_crc;
        n_trailer  = r_trailer;
        o_res_push = 1'b0;
        o_res      = '{crc_ok: 1'b0, payload_length: r_len, received_crc: r_trailer};
        if (r_in_vld) begin
            unique case (r_phase)
                PhSearch: begin
                    if (r_byte == r_preamble && r_slot) begin
                        n_crc     = crc24q_byte('0, r_byte);
                        n_trailer = '0;
                        n_len     = '0;
                        n_left    = '0;
                        n_phase   = PhLen1;
                    end
                end
                PhLen1: begin
                    n_crc   = crc_upd;
                    n_len   = {r_byte[1:0] & LenHiMask, 8'h00};
                    n_phase = PhLen2;
                end
                PhLen2: begin
                    n_crc   = crc_upd;
                    n_len   = len_full;
                    n_left  = {1'b0, len_full} + LeftW'(TrailerBytes);
                    n_phase = PhBody;
                end
                PhBody: begin
                    if (r_left > LeftW'(TrailerBytes)) begin
                        n_crc = crc_upd;
                    end else begin
                        n_trailer = {r_trailer[15:0], r_byte};
                    end
                    if (r_left <= LeftW'(1)) begin
                        n_left     = '0;
                        n_phase    = PhSearch;
                        o_res_push = 1'b1;
                        o_res      = '{crc_ok: (n_crc == n_trailer),
                                       payload_length: r_len,
                                       received_crc: n_trailer};
                    end else begin
                        n_left = r_left - LeftW'(1);
                    end
                end
                default: n_phase = PhSearch;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PhSearch;
            r_left     <= '0;
            r_len      <= '0;
            r_crc      <= '0;
            r_trailer  <= '0;
            r_preamble <= PreambleReset;
            r_in_vld   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_trailer <= n_trailer;
            r_in_vld  <= in_acc;
            if (i_cfg_we) begin
                r_preamble <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_data_byte;
            r_slot <= i_slot_free;
        end
    end

endmodule

/* rtl/rtcm3_res_queue.sv */
// ----------------------------------------------------------------------------
// RTCM3 result queue
// Small shift queue of frame results; head entry drives the output channel.
// ----------------------------------------------------------------------------
module rtcm3_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rtcm3_pkg::t_result i_res,
    output rtcm3_pkg::t_q_stat o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output rtcm3_pkg::t_result o_res
);
    import rtcm3_pkg::*;

    t_result               r_ent [ResQDepth];
    logic [ResQLevelW-1:0] r_level, n_level;
    logic                  pop;
    logic [ResQLevelW-1:0] wr_idx;

    assign o_valid      = (r_level != '0);
    assign pop          = o_valid && i_ready;
    assign wr_idx       = r_level - {{(ResQLevelW-1){1'b0}}, pop};
    assign n_level      = wr_idx + {{(ResQLevelW-1){1'b0}}, i_push};
    assign o_stat.level = r_level;
    assign o_res        = r_ent[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ResQDepth - 1; i++) begin
            if (pop) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
        for (int i = 0; i < ResQDepth; i++) begin
            if (i_push && wr_idx == ResQLevelW'(i)) begin
                r_ent[i] <= i_res;
            end
        end
    end

endmodule

/* rtl/rtcm3_frame_deframer_crc24q.sv */
// ----------------------------------------------------------------------------
// RTCM3 frame deframer with CRC-24Q check
// Byte stream in, one result per frame out.
// ----------------------------------------------------------------------------
// i_in carries one received byte per item together with the slot-free flag;
// a byte is taken at a clock edge where valid and ready are both high, and
// one byte can be taken every cycle while ready is high. o_out carries one
// item per completed frame: CRC match flag, payload length and trailer CRC.
// i_cfg_we/i_cfg_wdata write the preamble byte (0xD3 after reset); write it
// only while the block is idle.
// A frame's last accepted byte passes the input register, then the result
// queue, before it shows on o_out.valid. Throughput is one byte per cycle
// while i_in.ready is high, set by the combinational CRC-24Q byte update.
// A three-entry result queue sits in front of o_out. When the receiver
// stalls, results wait in the queue and bytes keep flowing until the queue
// could overflow, at which point i_in.ready drops.
// Synchronous reset returns the parser to preamble search, empties the queue
// and restores the preamble byte.
// ----------------------------------------------------------------------------
module rtcm3_frame_deframer_crc24q (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtcm3_in_if.sink    i_in,
    rtcm3_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import rtcm3_pkg::*;

    t_q_stat q_stat;
    logic    res_push;
    t_result res_in;
    t_result res_out;

    rtcm3_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .i_slot_free (i_in.slot_free),
        .o_in_ready  (i_in.ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    rtcm3_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_stat  (q_stat),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res_out)
    );

    assign o_out.crc_ok         = res_out.crc_ok;
    assign o_out.payload_length = res_out.payload_length;
    assign o_out.received_crc   = res_out.received_crc;

endmodule

/* rtl/rtcm3_chk.sv */
// ----------------------------------------------------------------------------
// RTCM3 deframer port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rtcm3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_crc_ok,
    input logic [9:0]  i_payload_length,
    input logic [23:0] i_received_crc
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    // with no result pending there is always room for another byte
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result queue");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_crc_ok) && $stable(i_payload_length) && $stable(i_received_crc))
        else $error("result changed while stalled");

endmodule

bind rtcm3_frame_deframer_crc24q rtcm3_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_crc_ok         (o_out.crc_ok),
    .i_payload_length (o_out.payload_length),
    .i_received_crc   (o_out.received_crc)
);
